/* design/isc_pkg.sv */
// Shared constants, types and helper functions of the infix to postfix converter.
package isc_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	typedef logic [CNT_W-1:0] count_t;
	typedef logic [2:0] op_t;
	typedef logic [2:0] err_t;

	localparam count_t STACK_FULL = count_t'(STACK_DEPTH);

	localparam op_t OP_LPAREN = 3'd0;
	localparam op_t OP_PLUS   = 3'd1;
	localparam op_t OP_MINUS  = 3'd2;
	localparam op_t OP_MUL    = 3'd3;
	localparam op_t OP_DIV    = 3'd4;
	localparam op_t OP_POW    = 3'd5;

	localparam err_t ERR_NONE      = 3'd0;
	localparam err_t ERR_INVALID   = 3'd1;
	localparam err_t ERR_UNMATCH_R = 3'd2;
	localparam err_t ERR_UNMATCH_L = 3'd3;
	localparam err_t ERR_OVERFLOW  = 3'd4;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MUL    = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DIV    = 8'h2F;
	localparam logic [7:0] CH_POW    = 8'h5E;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
		op_t  code;
	} stk_ctrl_t;

	typedef struct packed {
		count_t count;
		op_t    top;
		op_t    second;
	} stk_stat_t;

	// An open parenthesis ranks below every arithmetic operator.
	function automatic logic [1:0] op_prec(input op_t code);
		logic [1:0] p;
		case (code)
			OP_PLUS, OP_MINUS: p = 2'd1;
			OP_MUL, OP_DIV:    p = 2'd2;
			OP_POW:            p = 2'd3;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] op_char(input op_t code);
		logic [7:0] c;
		case (code)
			OP_LPAREN: c = CH_LPAREN;
			OP_PLUS:   c = CH_PLUS;
			OP_MINUS:  c = CH_MINUS;
			OP_MUL:    c = CH_MUL;
			OP_DIV:    c = CH_DIV;
			OP_POW:    c = CH_POW;
			default:   c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

/* design/isc_if.sv */
// Handshake channels for expression characters and postfix results.
interface isc_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] symbol;

	modport source (output valid, output kind, output symbol, input ready);
	modport sink (input valid, input kind, input symbol, output ready);
endinterface

interface isc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_symbol;
	logic       symbol_valid;
	logic [2:0] error_code;
	logic       expression_done;
	logic       last;

	modport source (output valid, output out_symbol, output symbol_valid, output error_code,
		output expression_done, output last, input ready);
	modport sink (input valid, input out_symbol, input symbol_valid, input error_code,
		input expression_done, input last, output ready);
endinterface

/* design/infix_to_postfix_converter.sv */
// Top level of the infix to postfix converter with its control sequencer.
//
//  Port     | Dir  | Item
//  ---------+------+---------------------------------------------------------
//  expr     | in   | kind, symbol: one expression character or the end marker
//  postfix  | out  | out_symbol, symbol_valid, error_code, expression_done, last
//
// A letter, space, '(', '^' or invalid character is handled in the idle state alone.
// '+', '-', '*', '/', ')' and an end marker on a non-empty stack are accepted in the idle state,
// then pop one operator per step in their own state and end with a closing step; the operator
// stack contents set how many pops there are. An end marker on an empty stack stays in idle.
// Results sit in one output register; a stalled postfix port holds the sequencer.
// Reset clears the stack count, the sequencer and the output valid flag.
module infix_to_postfix_converter (
	input  logic              clk,
	input  logic              arst_n,
	isc_in_if.sink            expr,
	isc_out_if.source         postfix
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_OPS   = 2'd1;
	localparam logic [1:0] ST_RPAR  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q, state_d;
	isc_pkg::op_t code_q, code_d;
	logic open_q, open_d;

	isc_pkg::stk_ctrl_t ctrl;
	isc_pkg::stk_stat_t stat;

	logic out_valid_q;
	logic [7:0] sym_q;
	logic sv_q, done_q, last_q;
	isc_pkg::err_t err_q;

	logic emit, can_emit, is_letter, empty, full;
	logic [7:0] r_sym;
	logic r_sv, r_done, r_last;
	isc_pkg::err_t r_err;

	isc_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	assign can_emit = !out_valid_q || postfix.ready;
	assign expr.ready = (state_q == ST_IDLE) && can_emit;
	assign empty = (stat.count == '0);
	assign full = (stat.count == isc_pkg::STACK_FULL);
	assign is_letter = (expr.symbol >= isc_pkg::CH_UPPER_A && expr.symbol <= isc_pkg::CH_UPPER_Z)
		|| (expr.symbol >= isc_pkg::CH_LOWER_A && expr.symbol <= isc_pkg::CH_LOWER_Z);

	always_comb begin
		emit = 1'b0;
		r_sym = 8'd0;
		r_sv = 1'b0;
		r_err = isc_pkg::ERR_NONE;
		r_done = 1'b0;
		r_last = 1'b0;
		ctrl = '0;
		ctrl.code = code_q;
		state_d = state_q;
		code_d = code_q;
		open_d = open_q;
		case (state_q)
			ST_IDLE: begin
				if (expr.valid && can_emit) begin
					if (expr.kind) begin
						if (empty) begin
							emit = 1'b1;
							r_done = 1'b1;
							r_last = 1'b1;
						end else begin
							open_d = 1'b0;
							state_d = ST_FLUSH;
						end
					end else if (expr.symbol == isc_pkg::CH_SPACE) begin
						emit = 1'b0;
					end else if (is_letter) begin
						emit = 1'b1;
						r_sym = expr.symbol;
						r_sv = 1'b1;
						r_last = 1'b1;
					end else if (expr.symbol == isc_pkg::CH_LPAREN
						|| expr.symbol == isc_pkg::CH_POW) begin
						if (full) begin
							emit = 1'b1;
							r_err = isc_pkg::ERR_OVERFLOW;
							r_done = 1'b1;
							r_last = 1'b1;
							ctrl.clear = 1'b1;
						end else begin
							ctrl.push = 1'b1;
							ctrl.code = (expr.symbol == isc_pkg::CH_LPAREN)
								? isc_pkg::OP_LPAREN : isc_pkg::OP_POW;
						end
					end else if (expr.symbol == isc_pkg::CH_PLUS) begin
						code_d = isc_pkg::OP_PLUS;
						state_d = ST_OPS;
					end else if (expr.symbol == isc_pkg::CH_MINUS) begin
						code_d = isc_pkg::OP_MINUS;
						state_d = ST_OPS;
					end else if (expr.symbol == isc_pkg::CH_MUL) begin
						code_d = isc_pkg::OP_MUL;
						state_d = ST_OPS;
					end else if (expr.symbol == isc_pkg::CH_DIV) begin
						code_d = isc_pkg::OP_DIV;
						state_d = ST_OPS;
					end else if (expr.symbol == isc_pkg::CH_RPAREN) begin
						state_d = ST_RPAR;
					end else begin
						emit = 1'b1;
						r_err = isc_pkg::ERR_INVALID;
						r_done = 1'b1;
						r_last = 1'b1;
						ctrl.clear = 1'b1;
					end
				end
			end
			ST_OPS: begin
				if (can_emit) begin
					if (!empty && isc_pkg::op_prec(stat.top) >= isc_pkg::op_prec(code_q)) begin
						ctrl.pop = 1'b1;
						emit = 1'b1;
						r_sym = isc_pkg::op_char(stat.top);
						r_sv = 1'b1;
						r_last = !(stat.count > isc_pkg::count_t'(1)
							&& isc_pkg::op_prec(stat.second) >= isc_pkg::op_prec(code_q));
					end else begin
						if (full) begin
							emit = 1'b1;
							r_err = isc_pkg::ERR_OVERFLOW;
							r_done = 1'b1;
							r_last = 1'b1;
							ctrl.clear = 1'b1;
						end else begin
							ctrl.push = 1'b1;
						end
						state_d = ST_IDLE;
					end
				end
			end
			ST_RPAR: begin
				if (can_emit) begin
					if (empty) begin
						emit = 1'b1;
						r_err = isc_pkg::ERR_UNMATCH_R;
						r_done = 1'b1;
						r_last = 1'b1;
						state_d = ST_IDLE;
					end else if (stat.top == isc_pkg::OP_LPAREN) begin
						ctrl.pop = 1'b1;
						state_d = ST_IDLE;
					end else begin
						ctrl.pop = 1'b1;
						emit = 1'b1;
						r_sym = isc_pkg::op_char(stat.top);
						r_sv = 1'b1;
						r_last = (stat.count > isc_pkg::count_t'(1))
							&& (stat.second == isc_pkg::OP_LPAREN);
					end
				end
			end
			ST_FLUSH: begin
				if (can_emit) begin
					if (empty) begin
						emit = 1'b1;
						r_err = open_q ? isc_pkg::ERR_UNMATCH_L : isc_pkg::ERR_NONE;
						r_done = 1'b1;
						r_last = 1'b1;
						state_d = ST_IDLE;
					end else if (stat.top == isc_pkg::OP_LPAREN) begin
						ctrl.pop = 1'b1;
						open_d = 1'b1;
					end else begin
						ctrl.pop = 1'b1;
						emit = 1'b1;
						r_sym = isc_pkg::op_char(stat.top);
						r_sv = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			open_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			open_q <= open_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (postfix.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_d;
		if (emit) begin
			sym_q <= r_sym;
			sv_q <= r_sv;
			err_q <= r_err;
			done_q <= r_done;
			last_q <= r_last;
		end
	end

	assign postfix.valid = out_valid_q;
	assign postfix.out_symbol = sym_q;
	assign postfix.symbol_valid = sv_q;
	assign postfix.error_code = err_q;
	assign postfix.expression_done = done_q;
	assign postfix.last = last_q;

endmodule

/* design/isc_cell.sv */
// One entry of the operator stack, shifting toward the top or the bottom.
module isc_cell (
	input  logic           clk,
	input  logic           push,
	input  logic           pop,
	input  isc_pkg::op_t   from_above,
	input  isc_pkg::op_t   from_below,
	output isc_pkg::op_t   code
);

	isc_pkg::op_t code_q;

	always_ff @(posedge clk) begin
		if (push) begin
			code_q <= from_above;
		end else if (pop) begin
			code_q <= from_below;
		end
	end

	assign code = code_q;

endmodule

/* design/isc_stack.sv */
// Operator stack built as a row of shifting cells with the top in cell zero.
module isc_stack (
	input  logic                clk,
	input  logic                arst_n,
	input  isc_pkg::stk_ctrl_t  ctrl,
	output isc_pkg::stk_stat_t  stat
);

	isc_pkg::op_t   cell_code [isc_pkg::STACK_DEPTH];
	isc_pkg::count_t count_q;

	for (genvar i = 0; i < isc_pkg::STACK_DEPTH; i++) begin : g_cell
		isc_pkg::op_t above;
		isc_pkg::op_t below;

		if (i == 0) begin : g_top
			assign above = ctrl.code;
		end else begin : g_mid
			assign above = cell_code[i-1];
		end

		if (i == isc_pkg::STACK_DEPTH - 1) begin : g_bottom
			assign below = isc_pkg::OP_LPAREN;
		end else begin : g_upper
			assign below = cell_code[i+1];
		end

		isc_cell u_cell (
			.clk        (clk),
			.push       (ctrl.push),
			.pop        (ctrl.pop),
			.from_above (above),
			.from_below (below),
			.code       (cell_code[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + isc_pkg::count_t'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - isc_pkg::count_t'(1);
		end
	end

	assign stat.count  = count_q;
	assign stat.top    = cell_code[0];
	assign stat.second = cell_code[1];

endmodule

/* design/isc_checker.sv */
// Port-level checks of the infix to postfix converter, bound to its top level.
module isc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_symbol,
	input logic       symbol_valid,
	input logic [2:0] error_code,
	input logic       expression_done,
	input logic       last
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(last)
			&& $stable(error_code))
		else $error("Stalled result changed.");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && symbol_valid |-> error_code == isc_pkg::ERR_NONE && !expression_done
			&& out_symbol != 8'd0)
		else $error("Character result carries error or done.");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expression_done |-> last && !symbol_valid)
		else $error("Done result is not the last of its item.");

	a_no_take_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("Item accepted while a result is stalled.");

endmodule

bind infix_to_postfix_converter isc_checker u_isc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (expr.ready),
	.out_valid       (postfix.valid),
	.out_ready       (postfix.ready),
	.out_symbol      (postfix.out_symbol),
	.symbol_valid    (postfix.symbol_valid),
	.error_code      (postfix.error_code),
	.expression_done (postfix.expression_done),
	.last            (postfix.last)
);

/* tb/postfix_result_check.sv */
// Predicts the postfix results of the converter and compares them with those taken from the block.
module postfix_result_check (
	input  logic clk,
	input  logic arst_n,
	isc_in_if    expr,
	isc_out_if   postfix,
	output int   fails,
	output int   pending
);

	typedef struct packed {
		logic [7:0]    out_symbol;
		logic          symbol_valid;
		isc_pkg::err_t error_code;
		logic          expression_done;
		logic          last;
	} postfix_item_t;

	isc_pkg::op_t  op_stack [isc_pkg::STACK_DEPTH];
	int            op_count;
	postfix_item_t produced [$];
	postfix_item_t awaited [$];
	postfix_item_t seen;
	postfix_item_t want;

	function automatic int rank(input isc_pkg::op_t op);
		int r;
		case (op)
			isc_pkg::OP_PLUS, isc_pkg::OP_MINUS: r = 1;
			isc_pkg::OP_MUL, isc_pkg::OP_DIV:    r = 2;
			isc_pkg::OP_POW:                     r = 3;
			default:                             r = -10;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] glyph(input isc_pkg::op_t op);
		logic [7:0] g;
		case (op)
			isc_pkg::OP_LPAREN: g = isc_pkg::CH_LPAREN;
			isc_pkg::OP_PLUS:   g = isc_pkg::CH_PLUS;
			isc_pkg::OP_MINUS:  g = isc_pkg::CH_MINUS;
			isc_pkg::OP_MUL:    g = isc_pkg::CH_MUL;
			isc_pkg::OP_DIV:    g = isc_pkg::CH_DIV;
			isc_pkg::OP_POW:    g = isc_pkg::CH_POW;
			default:            g = 8'd0;
		endcase
		return g;
	endfunction

	task automatic emit(input logic [7:0] sym, input logic sym_valid, input isc_pkg::err_t err,
		input logic done);
		postfix_item_t r;
		r.out_symbol      = sym;
		r.symbol_valid    = sym_valid;
		r.error_code      = err;
		r.expression_done = done;
		r.last            = 1'b0;
		produced.push_back(r);
	endtask

	task automatic push_operator(input isc_pkg::op_t op);
		if (op_count >= isc_pkg::STACK_DEPTH) begin
			op_count = 0;
			emit(8'd0, 1'b0, isc_pkg::ERR_OVERFLOW, 1'b1);
		end else begin
			op_stack[op_count] = op;
			op_count++;
		end
	endtask

	task automatic convert_item(input logic kind, input logic [7:0] c);
		isc_pkg::op_t op;
		logic         open_left;
		logic         matched;
		produced.delete();
		if (kind) begin
			open_left = 1'b0;
			while (op_count > 0) begin
				op_count--;
				if (op_stack[op_count] == isc_pkg::OP_LPAREN)
					open_left = 1'b1;
				else
					emit(glyph(op_stack[op_count]), 1'b1, isc_pkg::ERR_NONE, 1'b0);
			end
			emit(8'd0, 1'b0, open_left ? isc_pkg::ERR_UNMATCH_L : isc_pkg::ERR_NONE, 1'b1);
		end else if (c == isc_pkg::CH_SPACE) begin
		end else if ((c >= isc_pkg::CH_UPPER_A && c <= isc_pkg::CH_UPPER_Z) ||
			(c >= isc_pkg::CH_LOWER_A && c <= isc_pkg::CH_LOWER_Z)) begin
			emit(c, 1'b1, isc_pkg::ERR_NONE, 1'b0);
		end else if (c == isc_pkg::CH_LPAREN || c == isc_pkg::CH_POW) begin
			push_operator(c == isc_pkg::CH_LPAREN ? isc_pkg::OP_LPAREN : isc_pkg::OP_POW);
		end else if (c == isc_pkg::CH_PLUS || c == isc_pkg::CH_MINUS || c == isc_pkg::CH_MUL
			|| c == isc_pkg::CH_DIV) begin
			case (c)
				isc_pkg::CH_PLUS:  op = isc_pkg::OP_PLUS;
				isc_pkg::CH_MINUS: op = isc_pkg::OP_MINUS;
				isc_pkg::CH_MUL:   op = isc_pkg::OP_MUL;
				default:           op = isc_pkg::OP_DIV;
			endcase
			while (op_count > 0 && rank(op_stack[op_count - 1]) >= rank(op)) begin
				op_count--;
				emit(glyph(op_stack[op_count]), 1'b1, isc_pkg::ERR_NONE, 1'b0);
			end
			push_operator(op);
		end else if (c == isc_pkg::CH_RPAREN) begin
			matched = 1'b0;
			while (op_count > 0 && !matched) begin
				op_count--;
				if (op_stack[op_count] == isc_pkg::OP_LPAREN)
					matched = 1'b1;
				else
					emit(glyph(op_stack[op_count]), 1'b1, isc_pkg::ERR_NONE, 1'b0);
			end
			if (!matched)
				emit(8'd0, 1'b0, isc_pkg::ERR_UNMATCH_R, 1'b1);
		end else begin
			op_count = 0;
			emit(8'd0, 1'b0, isc_pkg::ERR_INVALID, 1'b1);
		end
		if (produced.size() > 0) begin
			produced[produced.size() - 1].last = 1'b1;
			foreach (produced[i])
				awaited.push_back(produced[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_count = 0;
			awaited.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (postfix.valid && postfix.ready) begin
				seen.out_symbol      = postfix.out_symbol;
				seen.symbol_valid    = postfix.symbol_valid;
				seen.error_code      = postfix.error_code;
				seen.expression_done = postfix.expression_done;
				seen.last            = postfix.last;
				if (awaited.size() == 0) begin
					if (fails < 10)
						$display("Unexpected postfix item: sym %h valid %b err %0d",
							seen.out_symbol, seen.symbol_valid, seen.error_code,
							" done %b last %b", seen.expression_done, seen.last);
					fails++;
				end else begin
					want = awaited.pop_front();
					if (seen !== want) begin
						if (fails < 10)
							$display("Postfix mismatch: expected sym %h valid %b err %0d",
								want.out_symbol, want.symbol_valid, want.error_code,
								" done %b last %b,", want.expression_done, want.last,
								" got sym %h valid %b err %0d", seen.out_symbol,
								seen.symbol_valid, seen.error_code,
								" done %b last %b", seen.expression_done, seen.last);
						fails++;
					end
				end
			end
			if (expr.valid && expr.ready)
				convert_item(expr.kind, expr.symbol);
			pending = awaited.size();
		end
	end

endmodule

/* tb/tb_infix_to_postfix_converter.sv */
// Testbench top of the infix to postfix converter: stimulus, flow control, watchdog and verdict.
module tb_infix_to_postfix_converter;

	localparam int ITEM_TARGET = 410;
	localparam int IDLE_LIMIT  = 1000;
	localparam int HOLD_OFF    = 150;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   n_sent = 0;
	int   taken = 0;
	int   idle_cycles = 0;
	logic steady_in = 1'b0;
	logic steady_out = 1'b0;

	isc_in_if  expr_ch ();
	isc_out_if post_ch ();

	infix_to_postfix_converter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.expr    (expr_ch),
		.postfix (post_ch)
	);

	postfix_result_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.expr    (expr_ch),
		.postfix (post_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] random_letter();
		if ($urandom_range(0, 1))
			return 8'(isc_pkg::CH_UPPER_A + $urandom_range(0, 25));
		return 8'(isc_pkg::CH_LOWER_A + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] pick_operator();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0:       c = isc_pkg::CH_PLUS;
			1:       c = isc_pkg::CH_MINUS;
			2:       c = isc_pkg::CH_MUL;
			3:       c = isc_pkg::CH_DIV;
			default: c = isc_pkg::CH_POW;
		endcase
		return c;
	endfunction

	task automatic send_item(input logic kind, input logic [7:0] sym);
		int gap;
		gap = steady_in ? 0 : $urandom_range(0, 3);
		if ($urandom_range(0, 19) == 0)
			steady_in = !steady_in;
		if (gap > 0) begin
			expr_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		expr_ch.valid  = 1'b1;
		expr_ch.kind   = kind;
		expr_ch.symbol = sym;
		do @(posedge clk); while (!expr_ch.ready);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
	endtask

	task automatic put_token(input logic [7:0] c);
		if ($urandom_range(0, 7) == 0)
			send_item(1'b0, isc_pkg::CH_SPACE);
		send_item(1'b0, c);
	endtask

	task automatic send_expression();
		int terms;
		int depth;
		terms = $urandom_range(1, 8);
		depth = 0;
		for (int k = 0; k < terms; k++) begin
			while (depth < 6 && $urandom_range(0, 3) == 0) begin
				put_token(isc_pkg::CH_LPAREN);
				depth++;
			end
			put_token(random_letter());
			while (depth > 0 && $urandom_range(0, 2) == 0) begin
				put_token(isc_pkg::CH_RPAREN);
				depth--;
			end
			if (k < terms - 1)
				put_token(pick_operator());
		end
		if ($urandom_range(0, 5) != 0) begin
			while (depth > 0) begin
				put_token(isc_pkg::CH_RPAREN);
				depth--;
			end
		end
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_nest();
		repeat ($urandom_range(28, 34))
			send_item(1'b0, $urandom_range(0, 1) ? isc_pkg::CH_LPAREN : isc_pkg::CH_POW);
		if ($urandom_range(0, 1))
			send_item(1'b0, pick_operator());
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// The receiver stalls per item, with a long hold-off at two item counts that backs the block up.
	initial begin
		int stall;
		post_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = steady_out ? 0 : $urandom_range(0, 3);
			if ($urandom_range(0, 19) == 0)
				steady_out = !steady_out;
			if (taken == 40 || taken == 400)
				stall = HOLD_OFF;
			if (stall > 0) begin
				post_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			post_ch.ready = 1'b1;
			do @(posedge clk); while (!post_ch.valid);
			taken++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((expr_ch.valid && expr_ch.ready) || (post_ch.valid && post_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		arst_n         = 1'b0;
		expr_ch.valid  = 1'b0;
		expr_ch.kind   = 1'b0;
		expr_ch.symbol = 8'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(1'b1, 8'hFF);
		send_text("A+B*C-D/E^F");
		send_item(1'b1, 8'h00);
		send_text("(a + z)^y^Z");
		send_item(1'b1, 8'h5A);
		send_text("A)");
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h80);
		send_item(1'b0, 8'h7F);
		send_text("@[`{");
		send_text("((A");
		send_item(1'b1, 8'h00);
		// A full stack of open parentheses makes the next operator overflow.
		repeat (isc_pkg::STACK_DEPTH) send_item(1'b0, isc_pkg::CH_LPAREN);
		send_item(1'b0, isc_pkg::CH_PLUS);
		repeat (isc_pkg::STACK_DEPTH + 1) send_item(1'b0, isc_pkg::CH_POW);
		send_item(1'b1, 8'h00);

		while (n_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_expression();
			end else if (pick == 7) begin
				repeat ($urandom_range(1, 5)) send_item(1'b0, 8'($urandom_range(0, 255)));
				send_item(1'b1, 8'($urandom_range(0, 255)));
			end else if (pick == 8) begin
				send_nest();
			end else begin
				send_item(1'b0, isc_pkg::CH_RPAREN);
				send_expression();
			end
		end
		expr_ch.valid = 1'b0;

		wait (pending == 0);
		repeat (20) @(negedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
